@@ rtl/udff_pkg.sv @@
// ============================================================================
// udff_pkg
// Shared types and constants for the unsigned decimal field formatter.
// ============================================================================
package udff_pkg;

    // Input value width and longest field that is emitted
    localparam int VALUE_BITS = 32;
    localparam int MAX_FIELD  = 64;

    // Decimal digits of the widest value (ten for 32 bits)
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS + 1);

    // Divide by ten: q = (t * RECIP_10) >> RECIP_SHIFT, exact for 32-bit t
    localparam logic [VALUE_BITS-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                    RECIP_SHIFT = 35;

    // Configuration word and field counter widths
    localparam int CFG_DATA_W = 7;
    localparam int CNT_W      = 7;
    localparam int POS_W      = 8;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FIELD_WIDTH     = 3'd0,
        CFG_PRECISION       = 3'd1,
        CFG_PRECISION_GIVEN = 3'd2,
        CFG_LEFT_JUSTIFY    = 3'd3,
        CFG_ZERO_FILL       = 3'd4,
        CFG_SPACE_SIGN      = 3'd5,
        CFG_PLUS_SIGN       = 3'd6
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIZE,
        ST_LAYOUT,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/unsigned_decimal_field_formatter.sv @@
// ============================================================================
// unsigned_decimal_field_formatter
// Formats an unsigned value as a printf-style decimal field, one ASCII
// character per strobe, with width, precision, fill and sign flags.
// ============================================================================
// A value is taken when start is high and busy is low. The block then
// splits the value into decimal digits with one shared divide-by-ten unit
// (a reciprocal multiply and a subtract), one digit per cycle, sizes the
// padding in the SIZE and LAYOUT states and streams the field out one
// character per cycle on out_char with strobe high; the final character
// carries is_last. The receiver cannot stall, so every character must be
// taken in its cycle. The digit count is none for zero at zero precision,
// otherwise 1 to 10, and the emitted field length is at most 64; an empty
// field returns no character. Busy stays high from the value being taken
// until its field is out. Configuration words are taken while the block is
// idle and start is low, so a word never lands under a value being formatted.
module unsigned_decimal_field_formatter
    import udff_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    // result channel
    output logic                  strobe,
    output logic [7:0]            out_char,
    output logic                  is_last,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [6:0] field_width_reg;
    logic [5:0] precision_reg;
    logic       precision_given_reg;
    logic       left_justify_reg;
    logic       zero_fill_reg;
    logic       space_sign_reg;
    logic       plus_sign_reg;

    logic [VALUE_BITS-1:0] t_reg, t_next;
    logic [3:0]            digits_reg [MAX_DIGITS];
    logic [DIG_IDX_W-1:0]  ndig_reg, ndig_next;
    logic [DIG_IDX_W-1:0]  dptr_reg, dptr_next;
    logic [CNT_W-1:0]      zeros_reg, zeros_next;
    logic [CNT_W-1:0]      spaces_reg, spaces_next;
    logic [POS_W-1:0]      b1_reg, b1_next;
    logic [POS_W-1:0]      b2_reg, b2_next;
    logic [POS_W-1:0]      b3_reg, b3_next;
    logic [POS_W-1:0]      b4_reg, b4_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [5:0]            pos_reg, pos_next;

    // ------------------------------------------------------------------
    // Shared divide-by-ten unit
    // ------------------------------------------------------------------
    logic [2*VALUE_BITS-1:0] prod;
    logic [VALUE_BITS-1:0]   quot;
    logic [VALUE_BITS-1:0]   times10;
    logic [VALUE_BITS-1:0]   rem;

    assign prod    = {{VALUE_BITS{1'b0}}, t_reg} * {{VALUE_BITS{1'b0}}, RECIP_10};
    assign quot    = {{RECIP_SHIFT-VALUE_BITS{1'b0}}, prod[2*VALUE_BITS-1:RECIP_SHIFT]};
    assign times10 = {quot[VALUE_BITS-4:0], 3'b000} + {quot[VALUE_BITS-2:0], 1'b0};
    assign rem     = t_reg - times10;

    // ------------------------------------------------------------------
    // Sizing and layout terms
    // ------------------------------------------------------------------
    logic                 accept;
    logic                 no_digits;
    logic                 has_sign;
    logic [7:0]           sign_char;
    logic [CNT_W-1:0]     prec_eff;
    logic [CNT_W-1:0]     ndig_w;
    logic [CNT_W-1:0]     zeros_raw;
    logic [CNT_W-1:0]     used;
    logic [CNT_W-1:0]     width_sat;
    logic [CNT_W-1:0]     spaces_raw;
    logic [CNT_W-1:0]     spaces_sgn;
    logic [POS_W-1:0]     total;
    logic [POS_W-1:0]     pos_w;
    logic                 in_digits;
    logic                 last_char;

    assign accept    = start && (state_reg == ST_IDLE);
    assign no_digits = (value == '0) && precision_given_reg && (precision_reg == 6'd0);
    assign has_sign  = space_sign_reg || plus_sign_reg;
    assign sign_char = space_sign_reg ? CH_SPACE : CH_PLUS;
    assign prec_eff  = precision_given_reg ? {1'b0, precision_reg} : '0;
    assign ndig_w    = {{CNT_W-DIG_IDX_W{1'b0}}, ndig_reg};
    assign zeros_raw = (prec_eff > ndig_w) ? (prec_eff - ndig_w) : '0;
    assign used      = zeros_raw + ndig_w;
    assign width_sat = (field_width_reg > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                             : field_width_reg;
    assign spaces_raw = (width_sat > used) ? (width_sat - used) : '0;
    assign spaces_sgn = (has_sign && (spaces_raw != '0)) ? (spaces_raw - 7'd1) : spaces_raw;
    assign total      = b4_next + (left_justify_reg ? {1'b0, spaces_reg} : '0);

    assign pos_w     = {2'b00, pos_reg};
    assign in_digits = (pos_w >= b3_reg) && (pos_w < b4_reg);
    assign last_char = (({1'b0, pos_reg} + 7'd1) == len_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = no_digits ? ST_SIZE : ST_CONVERT;
            end
            ST_CONVERT:
            begin
                if (quot == '0)
                    state_next = ST_SIZE;
            end
            ST_SIZE:
                state_next = ST_LAYOUT;
            ST_LAYOUT:
                state_next = (len_next != '0) ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (last_char)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        t_next      = t_reg;
        ndig_next   = ndig_reg;
        dptr_next   = dptr_reg;
        zeros_next  = zeros_reg;
        spaces_next = spaces_reg;
        pos_next    = pos_reg;

        // Layout boundaries: lead spaces, sign, zeros, digits, trail spaces
        b1_next  = left_justify_reg ? '0 : {1'b0, spaces_reg};
        b2_next  = b1_next + {7'd0, has_sign};
        b3_next  = b2_next + {1'b0, zeros_reg};
        b4_next  = b3_next + {1'b0, ndig_w};
        len_next = (total > POS_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : total[CNT_W-1:0];

        if (accept)
        begin
            t_next    = value;
            ndig_next = '0;
        end
        if (state_reg == ST_CONVERT)
        begin
            t_next    = quot;
            ndig_next = ndig_reg + 1'b1;
        end
        if (state_reg == ST_SIZE)
        begin
            // Zero fill without a precision turns the pad into zeros
            if (zero_fill_reg && !precision_given_reg)
            begin
                zeros_next  = spaces_sgn;
                spaces_next = '0;
            end
            else
            begin
                zeros_next  = zeros_raw;
                spaces_next = spaces_sgn;
            end
        end
        if (state_reg == ST_LAYOUT)
        begin
            pos_next  = '0;
            dptr_next = ndig_reg - 1'b1;
        end
        if (state_reg == ST_EMIT)
        begin
            pos_next = pos_reg + 1'b1;
            if (in_digits)
                dptr_next = dptr_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE) && !start;
        strobe    = (state_reg == ST_EMIT);
        is_last   = (state_reg == ST_EMIT) && last_char;
        priority if (pos_w < b1_reg)
            out_char = CH_SPACE;
        else if (pos_w < b2_reg)
            out_char = sign_char;
        else if (pos_w < b3_reg)
            out_char = CH_ZERO;
        else if (pos_w < b4_reg)
            out_char = CH_ZERO + {4'd0, digits_reg[dptr_reg]};
        else
            out_char = CH_SPACE;
    end

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            field_width_reg     <= '0;
            precision_reg       <= '0;
            precision_given_reg <= 1'b0;
            left_justify_reg    <= 1'b0;
            zero_fill_reg       <= 1'b0;
            space_sign_reg      <= 1'b0;
            plus_sign_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Write a configuration word
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FIELD_WIDTH:     field_width_reg     <= cfg_data;
                    CFG_PRECISION:       precision_reg       <= cfg_data[5:0];
                    CFG_PRECISION_GIVEN: precision_given_reg <= cfg_data[0];
                    CFG_LEFT_JUSTIFY:    left_justify_reg    <= cfg_data[0];
                    CFG_ZERO_FILL:       zero_fill_reg       <= cfg_data[0];
                    CFG_SPACE_SIGN:      space_sign_reg      <= cfg_data[0];
                    CFG_PLUS_SIGN:       plus_sign_reg       <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        ndig_reg   <= ndig_next;
        dptr_reg   <= dptr_next;
        zeros_reg  <= zeros_next;
        spaces_reg <= spaces_next;
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        b3_reg     <= b3_next;
        b4_reg     <= b4_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        // Store the next digit, least significant first
        if (state_reg == ST_CONVERT)
            digits_reg[ndig_reg] <= rem[3:0];
    end

endmodule
